### rtl/core/spi_master_mode0_assert.svh
// assertion macros shared by the spi master rtl
// expects signals named clk and rst_n in the including module
`ifndef SPI_MASTER_MODE0_ASSERT_SVH
`define SPI_MASTER_MODE0_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SPIM0_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spim0 assertion failed");

// next-cycle implication
`define SPIM0_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spim0 assertion failed");

`endif

### rtl/core/spim0_pkg.sv
// shared types and constants for the spi master (clock phase 0)
// no dependencies
package spim0_pkg;

    localparam int DELAY_BITS = 16;
    localparam int WORD_BITS  = 8;
    localparam int WAIT_W     = DELAY_BITS + 1;
    localparam int BIT_CNT_W  = $clog2(WORD_BITS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // item modes
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_SELECT   = 2'd1;
    localparam logic [1:0] MODE_DESELECT = 2'd2;
    localparam logic [1:0] MODE_XFER     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_POL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SELWAIT = 3'd1,
        PH_SETTLE  = 3'd2,
        PH_ACTIVE  = 3'd3,
        PH_LOW     = 3'd4
    } phase_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [WORD_BITS-1:0] tx_byte;
        logic                 miso;
    } in_item_t;

    typedef struct packed {
        logic                 sclk_level;
        logic                 mosi_level;
        logic                 cs_level;
        logic                 busy_res;
        logic [WORD_BITS-1:0] rx_byte;
        logic                 rx_done;
        logic                 rejected;
    } out_item_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

### rtl/core/spim0_if.sv
// valid/ready channel interfaces for items, results and register writes
// depends on spim0_pkg
interface spim0_in_if;
    import spim0_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [WORD_BITS-1:0] tx_byte;
    logic                 miso;
    modport source (output valid, output mode, output tx_byte, output miso, input ready);
    modport sink (input valid, input mode, input tx_byte, input miso, output ready);
endinterface

interface spim0_out_if;
    import spim0_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 sclk_level;
    logic                 mosi_level;
    logic                 cs_level;
    logic                 busy_res;
    logic [WORD_BITS-1:0] rx_byte;
    logic                 rx_done;
    logic                 rejected;
    modport source (output valid, output sclk_level, output mosi_level, output cs_level,
                    output busy_res, output rx_byte, output rx_done, output rejected,
                    input ready);
    modport sink (input valid, input sclk_level, input mosi_level, input cs_level,
                  input busy_res, input rx_byte, input rx_done, input rejected,
                  output ready);
endinterface

interface spim0_cfg_if;
    import spim0_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/spi_master_mode0.sv
// spi master, clock phase 0, one timing tick per item
// usage:
//   in_ch carries one item per tick: mode (tick, select, deselect, transfer),
//   tx_byte and the sampled miso level. out_ch returns one item per input
//   item with the sclk, mosi and cs line levels after that tick, busy, the
//   receive shift register, rx_done and rejected.
//   cfg_ch writes the polarity and delay registers by index; it is always
//   ready and should only be used while no item is in flight.
// path: an accepted item is held in the input register; its result is then written
//   into the result register once that has room, and out_ch takes it from there.
// throughput: one item per clock while out_ch is not stalled; the whole tick, including
//   chains of zero-length waits, is resolved in the single logic stage between them.
// reset: lines idle (clock low, select inactive high), delays one tick,
//   both stages empty; no clearing pass is needed.
// stall: if out_ch is not taken the result register holds, the input
//   register fills and in_ch ready drops until the result moves on.
// depends on spim0_pkg, spim0_if, spim0_in_stage, spim0_core, spim0_out_stage
module spi_master_mode0 (
    input  logic         clk,
    input  logic         rst_n,
    spim0_in_if.sink     in_ch,
    spim0_out_if.source  out_ch,
    spim0_cfg_if.sink    cfg_ch
);
    import spim0_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      can_load;
    logic      adv;
    out_item_t result;
    cfg_wr_t   cfg_wr;

    // an item advances when the result register has room
    assign adv = item_valid && can_load;

    // register writes are always taken
    assign cfg_ch.ready = 1'b1;
    assign cfg_wr       = '{valid: cfg_ch.valid, index: cfg_ch.index, data: cfg_ch.data};

    spim0_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (can_load),
        .item_valid (item_valid),
        .item       (item)
    );

    spim0_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (item),
        .cfg_wr (cfg_wr),
        .result (result)
    );

    spim0_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv),
        .res      (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

### rtl/core/spim0_in_stage.sv
// input register for the item channel
// depends on spim0_pkg and spim0_if
module spim0_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    spim0_in_if.sink            in_ch,
    input  logic                take,
    output logic                item_valid,
    output spim0_pkg::in_item_t item
);
    import spim0_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign in_ch.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid_reg <= in_ch.valid;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= '{mode: in_ch.mode, tx_byte: in_ch.tx_byte, miso: in_ch.miso};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/spim0_core.sv
// line state, bit timing and registers of the spi master
// depends on spim0_pkg and spi_master_mode0_assert.svh
`include "spi_master_mode0_assert.svh"

module spim0_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  spim0_pkg::in_item_t  item,
    input  spim0_pkg::cfg_wr_t   cfg_wr,
    output spim0_pkg::out_item_t result
);
    import spim0_pkg::*;

    localparam int STEP_MAX = 4;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_BITS - 1);

    typedef struct packed {
        phase_t               phase;
        logic [WAIT_W-1:0]    wait_cnt;
        logic [BIT_CNT_W-1:0] bit_cnt;
        logic [WORD_BITS-1:0] tx_shift;
        logic [WORD_BITS-1:0] rx_shift;
        logic                 clock_out;
        logic                 data_out;
        logic                 select_out;
    } core_state_t;

    logic                  clock_pol_reg;
    logic                  select_pol_reg;
    logic [DELAY_BITS-1:0] settle_reg;
    logic [DELAY_BITS-1:0] hold_reg;
    logic [DELAY_BITS-1:0] half_reg;
    core_state_t           state_reg;
    core_state_t           state_next;
    logic                  done;
    logic                  rejected;

    // next state for one tick, with zero-length waits chained in the same tick
    always_comb
    begin
        logic                 fast;
        logic [BIT_CNT_W-1:0] remain;
        logic [BIT_CNT_W:0]   samples;
        logic [WORD_BITS-1:0] fill;
        logic [BIT_CNT_W-1:0] last_pos;

        state_next = state_reg;
        done       = 1'b0;
        fast       = (settle_reg == '0) && (hold_reg == '0) && (half_reg == '0);
        rejected   = (item.mode != MODE_TICK) && (state_reg.phase != PH_IDLE);
        remain     = '0;
        samples    = '0;
        fill       = '0;
        last_pos   = '0;

        // command start or one tick of the running wait
        if ((item.mode != MODE_TICK) && (state_reg.phase == PH_IDLE))
        begin
            if (item.mode == MODE_XFER)
            begin
                state_next.rx_shift = '0;
                state_next.bit_cnt  = '0;
                state_next.data_out = item.tx_byte[WORD_BITS-1];
                state_next.tx_shift = item.tx_byte << 1;
                state_next.wait_cnt = {1'b0, settle_reg};
                state_next.phase    = PH_SETTLE;
            end
            else
            begin
                state_next.select_out = (item.mode == MODE_SELECT) ? select_pol_reg
                                                                    : !select_pol_reg;
                state_next.wait_cnt   = {1'b0, settle_reg};
                state_next.phase      = PH_SELWAIT;
            end
        end
        else if ((state_reg.phase != PH_IDLE) && (state_reg.wait_cnt != '0))
        begin
            state_next.wait_cnt = state_reg.wait_cnt - 1'b1;
        end

        if (fast && (state_next.phase != PH_IDLE) && (state_next.wait_cnt == '0))
        begin
            // all delays zero and the pending wait expired: the rest of the command
            // finishes in this tick
            if (state_next.phase == PH_SELWAIT)
            begin
                state_next.phase = PH_IDLE;
            end
            else
            begin
                remain   = LAST_BIT - state_next.bit_cnt;
                samples  = (state_next.phase == PH_LOW) ? {1'b0, remain}
                                                        : {1'b0, remain} + 1'b1;
                fill     = item.miso ? ~({WORD_BITS{1'b1}} << samples) : '0;
                last_pos = state_next.bit_cnt + 1'b1;
                state_next.rx_shift = (state_next.rx_shift << samples) | fill;
                if (remain != '0)
                begin
                    state_next.data_out = state_next.tx_shift[last_pos];
                end
                state_next.tx_shift  = state_next.tx_shift << remain;
                state_next.bit_cnt   = LAST_BIT;
                state_next.clock_out = clock_pol_reg;
                state_next.wait_cnt  = '0;
                state_next.phase     = PH_IDLE;
                done                 = 1'b1;
            end
        end
        else
        begin
            // at most STEP_MAX expired waits in a row when some delay is nonzero
            for (int i = 0; i < STEP_MAX; i++)
            begin
                if ((state_next.phase != PH_IDLE) && (state_next.wait_cnt == '0))
                begin
                    unique case (state_next.phase)
                        PH_SELWAIT:
                        begin
                            state_next.phase = PH_IDLE;
                        end
                        PH_SETTLE:
                        begin
                            state_next.clock_out = !clock_pol_reg;
                            state_next.wait_cnt  = {1'b0, hold_reg} + {1'b0, half_reg};
                            state_next.phase     = PH_ACTIVE;
                        end
                        PH_ACTIVE:
                        begin
                            state_next.rx_shift  = {state_next.rx_shift[WORD_BITS-2:0],
                                                    item.miso};
                            state_next.clock_out = clock_pol_reg;
                            state_next.wait_cnt  = {1'b0, half_reg};
                            state_next.phase     = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            if (state_next.bit_cnt == LAST_BIT)
                            begin
                                state_next.phase = PH_IDLE;
                                done             = 1'b1;
                            end
                            else
                            begin
                                state_next.bit_cnt  = state_next.bit_cnt + 1'b1;
                                state_next.data_out = state_next.tx_shift[WORD_BITS-1];
                                state_next.tx_shift = state_next.tx_shift << 1;
                                state_next.wait_cnt = {1'b0, settle_reg};
                                state_next.phase    = PH_SETTLE;
                            end
                        end
                        default:
                        begin
                            state_next.phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    // result fields
    always_comb
    begin
        result.sclk_level = state_next.clock_out;
        result.mosi_level = state_next.data_out;
        result.cs_level   = state_next.select_out;
        result.busy_res   = (state_next.phase != PH_IDLE);
        result.rx_byte    = state_next.rx_shift;
        result.rx_done    = done;
        result.rejected   = rejected;
    end

    // registers and line state; polarity writes move the lines to the new idle level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_pol_reg        <= 1'b0;
            select_pol_reg       <= 1'b0;
            settle_reg           <= DELAY_BITS'(1);
            hold_reg             <= DELAY_BITS'(1);
            half_reg             <= DELAY_BITS'(1);
            state_reg.phase      <= PH_IDLE;
            state_reg.wait_cnt   <= '0;
            state_reg.bit_cnt    <= '0;
            state_reg.tx_shift   <= '0;
            state_reg.rx_shift   <= '0;
            state_reg.clock_out  <= 1'b0;
            state_reg.data_out   <= 1'b0;
            state_reg.select_out <= 1'b1;
        end
        else if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                CFG_CLOCK_POL:
                begin
                    clock_pol_reg       <= cfg_wr.data[0];
                    state_reg.clock_out <= cfg_wr.data[0];
                end
                CFG_SELECT_POL:
                begin
                    select_pol_reg       <= cfg_wr.data[0];
                    state_reg.select_out <= !cfg_wr.data[0];
                end
                CFG_SETTLE:      settle_reg <= cfg_wr.data[DELAY_BITS-1:0];
                CFG_HOLD:        hold_reg   <= cfg_wr.data[DELAY_BITS-1:0];
                CFG_HALF_PERIOD: half_reg   <= cfg_wr.data[DELAY_BITS-1:0];
                default:
                begin
                    clock_pol_reg <= clock_pol_reg;
                end
            endcase
        end
        else if (adv)
        begin
            state_reg <= state_next;
        end
    end

    // a wait only expires into idle, so idle never carries a count
    `SPIM0_ASSERT_IMP(a_idle_no_wait, state_reg.phase == PH_IDLE, state_reg.wait_cnt == '0)
    // the clock is away from its idle level only during the active half
    `SPIM0_ASSERT_IMP(a_clock_idle_level, state_reg.phase != PH_ACTIVE, state_reg.clock_out == clock_pol_reg)
    // a finished transfer leaves the bit counter on the last bit
    `SPIM0_ASSERT_NXT(a_done_last_bit, adv && done, state_reg.bit_cnt == LAST_BIT)

endmodule

### rtl/core/spim0_out_stage.sv
// result register for the output channel
// depends on spim0_pkg, spim0_if and spi_master_mode0_assert.svh
`include "spi_master_mode0_assert.svh"

module spim0_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  spim0_pkg::out_item_t res,
    output logic                 can_load,
    spim0_out_if.source          out_ch
);
    import spim0_pkg::*;

    logic      valid_reg;
    out_item_t res_reg;

    // the register frees up in the same cycle its item is taken
    assign can_load = !valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.sclk_level = res_reg.sclk_level;
    assign out_ch.mosi_level = res_reg.mosi_level;
    assign out_ch.cs_level   = res_reg.cs_level;
    assign out_ch.busy_res   = res_reg.busy_res;
    assign out_ch.rx_byte    = res_reg.rx_byte;
    assign out_ch.rx_done    = res_reg.rx_done;
    assign out_ch.rejected   = res_reg.rejected;

    // a completed transfer always reports the master as free
    `SPIM0_ASSERT_IMP(a_done_not_busy, valid_reg && res_reg.rx_done, !res_reg.busy_res)

endmodule

### tb/testbench.sv
// self-checking testbench for spi_master_mode0: random and directed timing items
// are predicted by an in-file model of the spi line timing and checked per result
// depends on spim0_pkg, spim0_if and the spi_master_mode0 rtl
module testbench;
    import spim0_pkg::*;

    localparam int LIMIT_CYCLES    = 200_000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int BURST_ITEMS     = 110;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // clock
    always #4 clk = ~clk;

    spim0_in_if  in_ch();
    spim0_out_if out_ch();
    spim0_cfg_if cfg_ch();

    spi_master_mode0 dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // register copies
    logic                 cpol, spol;
    logic [15:0]          settle_t, hold_t, half_t;

    // predicted line state
    phase_t               ln_phase;
    logic [WAIT_W-1:0]    ln_wait;
    logic [BIT_CNT_W-1:0] ln_bit;
    logic [WORD_BITS-1:0] ln_tx, ln_rx;
    logic                 ln_sclk, ln_mosi, ln_cs;

    in_item_t  tick_q[$];
    out_item_t line_levels_q[$];
    in_item_t  drv_item, taken_item;
    out_item_t predicted, want;

    int errors        = 0;
    int cycles        = 0;
    int queued_total  = 0;
    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int hold_req      = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    bit in_fire       = 1'b0;

    // load the next data bit onto mosi and start the settle wait
    task automatic load_next_bit();
        ln_mosi  = ln_tx[WORD_BITS-1];
        ln_tx    = ln_tx << 1;
        ln_wait  = WAIT_W'(settle_t);
        ln_phase = PH_SETTLE;
    endtask

    // step taken when the running wait has run out
    task automatic expire_wait(input logic miso, inout logic done);
        case (ln_phase)
            PH_SETTLE:
            begin
                ln_sclk  = ~cpol;
                ln_wait  = WAIT_W'(hold_t) + WAIT_W'(half_t);
                ln_phase = PH_ACTIVE;
            end
            PH_ACTIVE:
            begin
                ln_rx    = {ln_rx[WORD_BITS-2:0], miso};
                ln_sclk  = cpol;
                ln_wait  = WAIT_W'(half_t);
                ln_phase = PH_LOW;
            end
            PH_LOW:
            begin
                if (ln_bit == BIT_CNT_W'(WORD_BITS - 1))
                begin
                    ln_phase = PH_IDLE;
                    done     = 1'b1;
                end
                else
                begin
                    ln_bit++;
                    load_next_bit();
                end
            end
            default:
                ln_phase = PH_IDLE;
        endcase
    endtask

    // one tick of line timing, with the command the item may carry
    task automatic step_spi_lines(input in_item_t it, output out_item_t res);
        logic rej;
        logic done;
        rej  = (it.mode != MODE_TICK) && (ln_phase != PH_IDLE);
        done = 1'b0;
        if (it.mode != MODE_TICK && ln_phase == PH_IDLE)
        begin
            if (it.mode == MODE_XFER)
            begin
                ln_tx  = it.tx_byte;
                ln_rx  = '0;
                ln_bit = '0;
                load_next_bit();
            end
            else
            begin
                ln_cs    = (it.mode == MODE_SELECT) ? spol : ~spol;
                ln_wait  = WAIT_W'(settle_t);
                ln_phase = PH_SELWAIT;
            end
        end
        else if (ln_phase != PH_IDLE && ln_wait != '0)
        begin
            ln_wait--;
        end
        // zero-length waits chain within the same tick
        while (ln_phase != PH_IDLE && ln_wait == '0)
            expire_wait(it.miso, done);
        res.sclk_level = ln_sclk;
        res.mosi_level = ln_mosi;
        res.cs_level   = ln_cs;
        res.busy_res   = (ln_phase != PH_IDLE);
        res.rx_byte    = ln_rx;
        res.rx_done    = done;
        res.rejected   = rej;
    endtask

    // register write as seen by the line state
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_CLOCK_POL:
            begin
                cpol    = value[0];
                ln_sclk = cpol;
            end
            CFG_SELECT_POL:
            begin
                spol  = value[0];
                ln_cs = ~spol;
            end
            CFG_SETTLE:      settle_t = value;
            CFG_HOLD:        hold_t   = value;
            CFG_HALF_PERIOD: half_t   = value;
            default: ;
        endcase
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_register(idx, value);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_item(input logic [1:0] mode, input logic [WORD_BITS-1:0] tx,
                             input logic miso);
        in_item_t it;
        it.mode    = mode;
        it.tx_byte = tx;
        it.miso    = miso;
        tick_q.push_back(it);
        queued_total++;
    endtask

    // plain ticks, with an occasional stray command when noisy
    task automatic add_ticks(input int n, input bit noisy);
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(0, 99) == 0)
                push_item(2'($urandom_range(MODE_SELECT, MODE_XFER)), 8'($urandom),
                          1'($urandom));
            else
                push_item(MODE_TICK, 8'($urandom), 1'($urandom));
        end
    endtask

    // mostly a little spare time, sometimes too short so the next command collides
    function automatic int slack();
        if ($urandom_range(0, 9) == 0)
            return -int'($urandom_range(1, 3));
        return int'($urandom_range(0, 2));
    endfunction

    function automatic int xfer_ticks();
        return WORD_BITS * (int'(settle_t) + int'(hold_t) + 2 * int'(half_t));
    endfunction

    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 16'd0;
        if (r < 85)
            return 16'($urandom_range(1, 3));
        return 16'($urandom_range(4, 8));
    endfunction

    // select, a few bytes, deselect
    task automatic add_frame();
        int nx;
        nx = $urandom_range(1, 4);
        push_item(MODE_SELECT, 8'($urandom), 1'($urandom));
        add_ticks(int'(settle_t) + slack(), 1'b1);
        repeat (nx)
        begin
            push_item(MODE_XFER, 8'($urandom), 1'($urandom));
            add_ticks(xfer_ticks() + slack(), 1'b1);
        end
        push_item(MODE_DESELECT, 8'($urandom), 1'($urandom));
        add_ticks(int'(settle_t) + slack(), 1'b1);
    endtask

    task automatic fill_burst(input int n);
        int start;
        start = queued_total;
        while (queued_total - start < n)
        begin
            if ($urandom_range(0, 99) < 80)
                add_frame();
            else
                push_item(2'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_setup();
        write_register(CFG_CLOCK_POL, 16'($urandom));
        write_register(CFG_SELECT_POL, 16'($urandom));
        write_register(CFG_SETTLE, pick_delay());
        write_register(CFG_HOLD, pick_delay());
        write_register(CFG_HALF_PERIOD, pick_delay());
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_HALF_PERIOD + CFG_IDX_W'($urandom_range(1, 3)), 16'($urandom));
        end_writes();
    endtask

    // wait until every queued item went in and every result came back
    task automatic wait_drained();
        @(posedge clk);
        while (tick_q.size() != 0 || in_ch.valid || line_levels_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [WORD_BITS-1:0] exp_v,
                               input logic [WORD_BITS-1:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endtask

    // item driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (!in_ch.valid || in_fire)
        begin
            if (tick_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                drv_item = tick_q.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.mode    <= drv_item.mode;
                in_ch.tx_byte <= drv_item.tx_byte;
                in_ch.miso    <= drv_item.miso;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // accepted items feed the line prediction
    always @(posedge clk)
    begin
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (in_fire)
        begin
            taken_item.mode    = in_ch.mode;
            taken_item.tx_byte = in_ch.tx_byte;
            taken_item.miso    = in_ch.miso;
            step_spi_lines(taken_item, predicted);
            line_levels_q.push_back(predicted);
        end
    end

    // result ready, with random stalls and requested long hold-offs
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_req != hold_served)
        begin
            hold_served  <= hold_served + 1;
            hold_left    <= HOLD_OFF_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= rst_n && ($urandom_range(0, 99) >= dst_stall_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (line_levels_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending, rx_byte %0h", $time, out_ch.rx_byte);
            end
            else
            begin
                want = line_levels_q.pop_front();
                check_field("sclk_level", want.sclk_level, out_ch.sclk_level);
                check_field("mosi_level", want.mosi_level, out_ch.mosi_level);
                check_field("cs_level", want.cs_level, out_ch.cs_level);
                check_field("busy_res", want.busy_res, out_ch.busy_res);
                check_field("rx_byte", want.rx_byte, out_ch.rx_byte);
                check_field("rx_done", want.rx_done, out_ch.rx_done);
                check_field("rejected", want.rejected, out_ch.rejected);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.mode    = MODE_TICK;
        in_ch.tx_byte = '0;
        in_ch.miso    = 1'b0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = CFG_CLOCK_POL;
        cfg_ch.data   = '0;

        // line state after reset
        cpol     = 1'b0;
        spol     = 1'b0;
        settle_t = 16'd1;
        hold_t   = 16'd1;
        half_t   = 16'd1;
        ln_phase = PH_IDLE;
        ln_wait  = '0;
        ln_bit   = '0;
        ln_tx    = '0;
        ln_rx    = '0;
        ln_sclk  = 1'b0;
        ln_mosi  = 1'b0;
        ln_cs    = 1'b1;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // idle tick, select, collision while busy, deselect at reset delays
        push_item(MODE_TICK, 8'h00, 1'b0);
        push_item(MODE_SELECT, 8'hFF, 1'b1);
        push_item(MODE_XFER, 8'h81, 1'b0);
        push_item(MODE_TICK, 8'hFF, 1'b1);
        push_item(MODE_DESELECT, 8'h00, 1'b0);
        push_item(MODE_TICK, 8'h00, 1'b1);
        wait_drained();

        // zero delays: a whole transfer resolves within one item
        write_register(CFG_SETTLE, 16'd0);
        write_register(CFG_HOLD, 16'd0);
        write_register(CFG_HALF_PERIOD, 16'd0);
        end_writes();
        push_item(MODE_SELECT, 8'h00, 1'b0);
        push_item(MODE_XFER, 8'hFF, 1'b1);
        push_item(MODE_XFER, 8'h00, 1'b0);
        push_item(MODE_XFER, 8'hA5, 1'b1);
        push_item(MODE_XFER, 8'h5A, 1'b0);
        push_item(MODE_DESELECT, 8'hFF, 1'b1);
        push_item(MODE_TICK, 8'h55, 1'b0);
        wait_drained();

        // long settle wait on a select
        write_register(CFG_SETTLE, 16'd40);
        end_writes();
        push_item(MODE_SELECT, 8'($urandom), 1'($urandom));
        add_ticks(40, 1'b1);
        add_ticks(2, 1'b0);
        wait_drained();

        // long active-clock wait, polarities flipped and delays zeroed in mid transfer
        write_register(CFG_SETTLE, 16'd0);
        write_register(CFG_HOLD, 16'd60);
        write_register(CFG_HALF_PERIOD, 16'd60);
        end_writes();
        push_item(MODE_XFER, 8'($urandom), 1'($urandom));
        add_ticks(30, 1'b1);
        wait_drained();
        write_register(CFG_CLOCK_POL, 16'hFFFF);
        write_register(CFG_SELECT_POL, 16'h0001);
        write_register(CFG_HOLD, 16'd0);
        write_register(CFG_HALF_PERIOD, 16'd0);
        write_register(CFG_HALF_PERIOD + CFG_IDX_W'(1), 16'hFFFF);
        end_writes();
        add_ticks(100, 1'b1);
        add_ticks(3, 1'b0);
        wait_drained();

        // random frames under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 50; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 50; end
                default: begin src_idle_pct = 28; dst_stall_pct = 28; end
            endcase
            for (int s = 0; s < 2; s++)
            begin
                random_setup();
                // receiver holds off while items keep coming
                if (p == 0 && s == 1)
                    hold_req++;
                fill_burst(BURST_ITEMS);
                wait_drained();
            end
        end

        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### spi_master_mode0.f
+incdir+rtl/core
rtl/core/spim0_pkg.sv
rtl/core/spim0_if.sv
rtl/core/spim0_in_stage.sv
rtl/core/spim0_core.sv
rtl/core/spim0_out_stage.sv
rtl/core/spi_master_mode0.sv
tb/testbench.sv
